### hw/rtl/meu_pkg.sv
// Shared types for the modular exponentiation unit: item structs and the
// command and status bundles between controller and datapath.
// No dependencies.
package meu_pkg;

  // Width of the base, exponent, modulus and power fields of an item on the ports.
  localparam int FIELD_W = 32;

  // One input item.
  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [FIELD_W-1:0] power;
    logic               bad_modulus;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture an input item, set the running value to one
    logic mul_go;       // start one modular multiply
    logic mul_sel_base; // multiplier operand is the base, else the running value
    logic acc_wr;       // write the multiply result into the running value
    logic bit_next;     // move on to the next lower exponent bit
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_busy;  // modular multiply still iterating
    logic cur_bit;   // exponent bit under scan
    logic last_bit;  // scan is at bit zero
    logic exp_zero;  // exponent of the item is zero
    logic mod_zero;  // modulus of the item is zero
  } dp_status_t;

endpackage

### hw/rtl/meu_ctrl.sv
// Controller of the modular exponentiation unit: a one-hot state machine that
// sequences squarings and multiplies over the exponent bits.
// Depends on meu_pkg.
module meu_ctrl
  import meu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_CHECK   = 8'b0000_0010,
    ST_SQ_GO   = 8'b0000_0100,
    ST_SQ_RUN  = 8'b0000_1000,
    ST_MUL_GO  = 8'b0001_0000,
    ST_MUL_RUN = 8'b0010_0000,
    ST_NEXT    = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A zero modulus or a zero exponent needs no arithmetic.
        if (status.mod_zero || status.exp_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        if (!status.mul_busy) begin
          cmd.acc_wr = 1'b1;
          state_nxt  = status.cur_bit ? ST_MUL_GO : ST_NEXT;
        end
      end
      ST_MUL_GO: begin
        cmd.mul_go       = 1'b1;
        cmd.mul_sel_base = 1'b1;
        state_nxt        = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        if (!status.mul_busy) begin
          cmd.acc_wr = 1'b1;
          state_nxt  = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status.last_bit) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.bit_next = 1'b1;
          state_nxt    = ST_SQ_GO;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

### hw/rtl/meu_dp.sv
// Datapath of the modular exponentiation unit: operand registers, the running
// value and a shift-and-add modular multiplier that takes one bit per cycle.
// Depends on meu_pkg.
module meu_dp
  import meu_pkg::*;
#(
  parameter int WIDTH    = 32,
  parameter int EXP_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  out_item
);

  localparam int MCNT_W = $clog2(WIDTH);
  localparam int BCNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  logic [WIDTH-1:0]    base_r;
  logic [WIDTH-1:0]    mod_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [BCNT_W-1:0]   bit_cnt_r;
  logic [WIDTH-1:0]    acc_r;

  logic [WIDTH-1:0]    mm_r;
  logic [WIDTH-1:0]    mm_b_r;
  logic [MCNT_W-1:0]   mm_cnt_r;
  logic                mm_busy_r;

  logic [WIDTH:0]      mm_dbl;
  logic [WIDTH-1:0]    mm_red;
  logic [WIDTH:0]      mm_sum;
  logic [WIDTH-1:0]    mm_nxt;

  // Operand capture, exponent scan and running value.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r    <= in_item.base[WIDTH-1:0];
      mod_r     <= in_item.modulus[WIDTH-1:0];
      exp_r     <= in_item.exponent[EXP_BITS-1:0];
      bit_cnt_r <= BCNT_W'(EXP_BITS - 1);
      acc_r     <= WIDTH'(1);
    end else begin
      if (cmd.bit_next) begin
        exp_r     <= exp_r << 1;
        bit_cnt_r <= bit_cnt_r - BCNT_W'(1);
      end
      if (cmd.acc_wr) begin
        acc_r <= mm_r;
      end
    end
  end

  // One step of the modular multiply acc * b mod m, multiplier bits MSB first.
  // The partial result stays below m, so each reduction is one compare and
  // subtract.
  always_comb begin
    mm_dbl = {mm_r, 1'b0};
    if (mm_dbl >= {1'b0, mod_r}) begin
      mm_red = WIDTH'(mm_dbl - {1'b0, mod_r});
    end else begin
      mm_red = mm_dbl[WIDTH-1:0];
    end
    mm_sum = {1'b0, mm_red} + (mm_b_r[WIDTH-1] ? {1'b0, acc_r} : '0);
    if (mm_sum >= {1'b0, mod_r}) begin
      mm_nxt = WIDTH'(mm_sum - {1'b0, mod_r});
    end else begin
      mm_nxt = mm_sum[WIDTH-1:0];
    end
  end

  // Multiplier control: busy from a start until the step count reaches zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_busy_r <= 1'b0;
    end else if (cmd.mul_go) begin
      mm_busy_r <= 1'b1;
    end else if (mm_busy_r && (mm_cnt_r == '0)) begin
      mm_busy_r <= 1'b0;
    end
  end

  // Multiplier partial result, multiplier operand and step count.
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mm_r     <= '0;
      mm_b_r   <= cmd.mul_sel_base ? base_r : acc_r;
      mm_cnt_r <= MCNT_W'(WIDTH - 1);
    end else if (mm_busy_r) begin
      mm_r     <= mm_nxt;
      mm_b_r   <= mm_b_r << 1;
      mm_cnt_r <= mm_cnt_r - MCNT_W'(1);
    end
  end

  // Status back to the controller.
  assign status.mul_busy = mm_busy_r;
  assign status.cur_bit  = exp_r[EXP_BITS-1];
  assign status.last_bit = (bit_cnt_r == '0);
  assign status.exp_zero = (exp_r == '0);
  assign status.mod_zero = (mod_r == '0);

  // Result item; a zero modulus reports power zero.
  assign out_item.power       = status.mod_zero ? '0 : FIELD_W'(acc_r);
  assign out_item.bad_modulus = status.mod_zero;

endmodule

### hw/rtl/modular_exponentiation_unit.sv
// Modular exponentiation unit, top level: base ** exponent mod modulus.
// Depends on meu_pkg, meu_ctrl and meu_dp.
//
// An item is taken when start is high while busy is low; one item is worked at
// a time. The exponent's low EXP_BITS bits are scanned from the top down: each
// bit costs a squaring and, for a one bit, a multiply by the base, and each
// modular multiply is a shift-and-add loop that resolves one multiplier bit
// per cycle. A zero exponent or a zero modulus skips the arithmetic. The
// result appears on out_item for exactly one cycle with out_valid high and
// must be captured then, since the receiver cannot hold it off. A zero
// modulus sets bad_modulus with power zero; a zero exponent gives power one.
module modular_exponentiation_unit
  import meu_pkg::*;
#(
  parameter int WIDTH    = 32,
  parameter int EXP_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  meu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and operand storage.
  meu_dp #(
    .WIDTH    (WIDTH),
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

### tb/sv/tb_modular_exponentiation_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for modular_exponentiation_unit: a directed table
// followed by random items, each result checked against a square-and-multiply predictor.
// Depends on meu_pkg and the modular_exponentiation_unit RTL.
module tb_modular_exponentiation_unit;
  import meu_pkg::*;

  localparam int WIDTH        = 32;
  localparam int EXP_BITS     = 32;
  localparam int RANDOM_ITEMS = 121;
  localparam int MAX_GAP      = 13;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // One row of the directed table; when has_fixed is set the expected result
  // is given here rather than by the predictor.
  typedef struct {
    in_item_t  item;
    bit        has_fixed;
    out_item_t fixed;
  } directed_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  out_item_t     pending_powers[$];
  directed_row_t directed_rows[$];
  int            mismatch_count;

  modular_exponentiation_unit #(
    .WIDTH   (WIDTH),
    .EXP_BITS(EXP_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Free-running clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Left-to-right square-and-multiply on 64-bit intermediates.
  function automatic out_item_t modpow_predict(in_item_t it);
    longint unsigned b;
    longint unsigned e;
    longint unsigned m;
    longint unsigned acc;
    int              top;
    out_item_t       r;
    b   = it.base & ((64'd1 << WIDTH) - 1);
    e   = it.exponent & ((64'd1 << EXP_BITS) - 1);
    m   = it.modulus & ((64'd1 << WIDTH) - 1);
    r   = '0;
    acc = 1;
    top = -1;
    if (m == 0) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    for (int k = 0; k < EXP_BITS; k++) begin
      if (e[k]) top = k;
    end
    for (int k = top; k >= 0; k--) begin
      acc = (acc * acc) % m;
      if (e[k]) acc = (acc * b) % m;
    end
    r.power = acc[FIELD_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [31:0] b, input logic [31:0] e, input logic [31:0] m,
                         input bit has_fixed, input logic [31:0] pw, input logic bad);
    directed_row_t row;
    row.item.base          = b;
    row.item.exponent      = e;
    row.item.modulus       = m;
    row.has_fixed          = has_fixed;
    row.fixed.power        = pw;
    row.fixed.bad_modulus  = bad;
    directed_rows.push_back(row);
  endtask

  // Presents one item after a random gap and holds it until busy is low at
  // a rising edge. Entered and left at a falling edge.
  task automatic send_item(input in_item_t it, input out_item_t expected);
    int gap;
    gap = $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_powers.push_back(expected);
    @(negedge clk);
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_powers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: power=%h bad_modulus=%b",
                   out_item.power, out_item.bad_modulus);
      end else begin
        want = pending_powers.pop_front();
        if (out_item.power !== want.power || out_item.bad_modulus !== want.bad_modulus) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected power=%h bad_modulus=%b, got power=%h bad_modulus=%b",
                     want.power, want.bad_modulus, out_item.power, out_item.bad_modulus);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    in_item_t  it;
    out_item_t want;
    int        kind;
    mismatch_count = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;

    // Directed table: zero modulus, zero exponent, modulus one, extremes,
    // and a base that is not below the modulus.
    add_row(32'd5,        32'd3,        32'd0,        1, 32'd0, 1'b1);
    add_row(32'd0,        32'd0,        32'd0,        1, 32'd0, 1'b1);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,        1, 32'd0, 1'b1);
    add_row(32'd7,        32'd0,        32'd13,       1, 32'd1, 1'b0);
    add_row(32'd7,        32'd0,        32'd1,        1, 32'd1, 1'b0);
    add_row(32'hFFFFFFFF, 32'd0,        32'hFFFFFFFF, 1, 32'd1, 1'b0);
    add_row(32'd9,        32'd5,        32'd1,        1, 32'd0, 1'b0);
    add_row(32'd5,        32'd1,        32'd7,        1, 32'd5, 1'b0);
    add_row(32'd0,        32'd5,        32'd11,       1, 32'd0, 1'b0);
    add_row(32'd1,        32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'd1, 1'b0);
    add_row(32'hFFFFFFFF, 32'd2,        32'hFFFFFFFF, 1, 32'd0, 1'b0);
    add_row(32'd4,        32'd13,       32'd497,      0, 32'd0, 1'b0);
    add_row(32'd100,      32'd3,        32'd7,        0, 32'd0, 1'b0);
    add_row(32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 32'd0, 1'b0);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFB, 0, 32'd0, 1'b0);
    add_row(32'h80000000, 32'h80000000, 32'h80000001, 0, 32'd0, 1'b0);
    add_row(32'h12345678, 32'h9ABCDEF0, 32'h7FFFFFFF, 0, 32'd0, 1'b0);
    add_row(32'd2,        32'd31,       32'hFFFFFFFF, 0, 32'd0, 1'b0);
    add_row(32'hDEADBEEF, 32'd1,        32'd2,        0, 32'd0, 1'b0);

    // Synchronous reset, released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].has_fixed ? directed_rows[i].fixed
                                        : modpow_predict(directed_rows[i].item);
      send_item(directed_rows[i].item, want);
    end
    wait_for_drain();

    // Random items, weighted toward the special cases now and then.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      it.base     = $urandom;
      it.exponent = $urandom;
      it.modulus  = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
        0: it.modulus  = '0;
        1: it.exponent = '0;
        2: it.modulus  = $urandom_range(1, 2);
        3: it.modulus  = $urandom_range(1, 255);
        4: it.exponent = $urandom_range(0, 15);
        5: it.base     = $urandom_range(0, 3);
        default: ;
      endcase
      send_item(it, modpow_predict(it));
    end
    start <= 1'b0;

    // Let outstanding results arrive, then watch for strays.
    while (pending_powers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
